// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file scfp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/scfp_pkg.sv -----
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants of the framed packet parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

  localparam int unsigned MAX_PAYLOAD    = 128;
  localparam int unsigned HEADER_BYTES   = 5;
  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned POS_W          = 9;
  localparam logic [POS_W-1:0] POS_MAX   = '1;

  localparam logic [0:0] CFG_START_MARKER = 1'd0;
  localparam logic [0:0] CFG_END_MARKER   = 1'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] VERDICT_OK         = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd1;
  localparam logic [2:0] VERDICT_BAD_MARKER = 3'd2;
  localparam logic [2:0] VERDICT_LEN_ERR    = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM   = 3'd4;
  localparam logic [2:0] VERDICT_TOO_LONG   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_package;
  } byte_beat_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [7:0] dest_address;
    logic [7:0] source_address;
    logic [7:0] command_code;
    logic [7:0] payload_count;
  } result_beat_t;

endpackage

`default_nettype wire

// ----- sv/scfp_frame.sv -----
// ----------------------------------------------------------------------------
// scfp_frame
// Frame state (position, sum, header) and per-beat result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scfp_frame import scfp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  byte_beat_t        beat,
  input  wire logic [7:0]   start_marker,
  input  wire logic [7:0]   end_marker,
  output logic              res_valid,
  output result_beat_t      res
);

  localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W:0]   MIN_LAST  = (POS_W+1)'(FRAME_OVERHEAD - 1);
  localparam logic [8:0]       MAX_PL    = 9'(MAX_PAYLOAD);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       held_dest, held_dest_next;
  logic [7:0]       held_source, held_source_next;
  logic [7:0]       held_command, held_command_next;
  logic [7:0]       held_length, held_length_next;
  logic             start_seen_ok, start_seen_ok_next;
  logic             sum_matched, sum_matched_next;

  logic [POS_W-1:0] body_off;
  logic             is_payload;
  logic [2:0]       verdict;
  logic [7:0]       b;

  assign b        = beat.data_byte;
  assign body_off = byte_position - HDR_POS;

  always_comb begin
    held_dest_next     = held_dest;
    held_source_next   = held_source;
    held_command_next  = held_command;
    held_length_next   = held_length;
    start_seen_ok_next = start_seen_ok;
    sum_matched_next   = sum_matched;
    running_sum_next   = running_sum;
    is_payload         = 1'b0;
    if (byte_position < HDR_POS) begin
      unique case (byte_position[2:0])
        3'd0:    start_seen_ok_next = (b == start_marker);
        3'd1:    held_dest_next     = b;
        3'd2:    held_source_next   = b;
        3'd3:    held_command_next  = b;
        default: held_length_next   = b;
      endcase
      running_sum_next = running_sum + b;
    end else if (body_off < {1'b0, held_length}) begin
      running_sum_next = running_sum + b;
      is_payload       = 1'b1;
    end else if (body_off == {1'b0, held_length}) begin
      sum_matched_next = (b == running_sum);
    end
  end

  // pos + 1 < 7  <=>  pos < 6 ;  pos + 1 == L + 7  <=>  pos == L + 6
  always_comb begin
    priority if ({1'b0, byte_position} < MIN_LAST) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (!start_seen_ok_next || b != end_marker) begin
      verdict = VERDICT_BAD_MARKER;
    end else if ({1'b0, byte_position} != ((POS_W+1)'(held_length_next) + MIN_LAST)) begin
      verdict = VERDICT_LEN_ERR;
    end else if (!sum_matched_next) begin
      verdict = VERDICT_CHECKSUM;
    end else if ({1'b0, held_length_next} >= MAX_PL) begin
      verdict = VERDICT_TOO_LONG;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    res.dest_address   = held_dest_next;
    res.source_address = held_source_next;
    res.command_code   = held_command_next;
    res.payload_count  = held_length_next;
    if (beat.end_of_package) begin
      res.item_kind    = KIND_VERDICT;
      res.payload_byte = 8'd0;
      res.verdict      = verdict;
      res_valid        = fire;
    end else begin
      res.item_kind    = KIND_PAYLOAD;
      res.payload_byte = b;
      res.verdict      = VERDICT_OK;
      res_valid        = fire && is_payload;
    end
    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                     : byte_position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && beat.end_of_package)) begin
      byte_position <= '0;
      running_sum   <= '0;
      held_dest     <= '0;
      held_source   <= '0;
      held_command  <= '0;
      held_length   <= '0;
      start_seen_ok <= 1'b0;
      sum_matched   <= 1'b0;
    end else if (fire) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      held_dest     <= held_dest_next;
      held_source   <= held_source_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      start_seen_ok <= start_seen_ok_next;
      sum_matched   <= sum_matched_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/scfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// scfp_out_buf
// Two-entry result buffer; room is a registered status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scfp_out_buf import scfp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  result_beat_t push_beat,
  output logic         room,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_beat_t result_beat
);

  result_beat_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != 2'd0);
  assign result_beat  = entry[rd_ptr];
  assign room         = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_beat;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sum_checksum_frame_parser_core.sv -----
// An accepted byte beat is registered in a hold register; the frame logic forms
// its result combinationally, and the result buffer stores it when it has room.
// Throughput: one byte beat per cycle while the result side keeps up.
// The two-entry result buffer stops intake only when both entries are full.
// Reset (rst, synchronous): clears frame state, buffer, and both markers to 0.
// ----------------------------------------------------------------------------
// sum_checksum_frame_parser_core
// Byte-stream parser for marker/length framed packets with an 8-bit sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sum_checksum_frame_parser_core import scfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  byte_beat_t      byte_beat,
  output logic            result_valid,
  input  wire logic       result_stall,
  output result_beat_t    result_beat,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0]   start_marker_q;
  logic [7:0]   end_marker_q;
  logic         hold_valid;
  byte_beat_t   hold_beat;
  logic         room;
  logic         fire;
  logic         res_valid;
  result_beat_t res;

  assign fire       = hold_valid && room;
  assign byte_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker_q <= '0;
      end_marker_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker_q <= cfg_data;
        CFG_END_MARKER:   end_marker_q   <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_beat <= byte_beat;
    end
  end

  scfp_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .beat         (hold_beat),
    .start_marker (start_marker_q),
    .end_marker   (end_marker_q),
    .res_valid    (res_valid),
    .res          (res)
  );

  scfp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_beat    (res),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

`default_nettype wire

// ----- sv/scfp_checker.sv -----
// ----------------------------------------------------------------------------
// scfp_checker
// Port-level checks on the parser result channel; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scfp_checker import scfp_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   result_valid,
  input wire logic   result_stall,
  input result_beat_t result_beat
);

  `CHK_ASSERT(a_valid_hold, clk, rst, result_valid && result_stall |=> result_valid, "result beat dropped while stalled")
  `CHK_ASSERT(a_beat_hold, clk, rst, result_valid && result_stall |=> $stable(result_beat), "stalled result beat changed")
  `CHK_ASSERT(a_verdict_form, clk, rst, result_valid && result_beat.item_kind == KIND_VERDICT |-> result_beat.payload_byte == 8'd0 && result_beat.verdict <= VERDICT_TOO_LONG, "malformed verdict beat")
  `CHK_ASSERT(a_payload_form, clk, rst, result_valid && result_beat.item_kind == KIND_PAYLOAD |-> result_beat.verdict == VERDICT_OK, "payload beat carries a verdict")
  `CHK_ASSERT_RST(a_reset_empty, clk, rst |=> !result_valid, "result valid right after reset")

endmodule

bind sum_checksum_frame_parser_core scfp_checker u_scfp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_beat  (result_beat)
);

`default_nettype wire

// ----- verif/scfp_frame_checker.sv -----
// ----------------------------------------------------------------------------
// scfp_frame_checker
// Watches the byte and result channels of the framed packet parser, tracks
// the marker registers through the write port, predicts every result from
// each accepted byte beat and compares the results field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfp_frame_checker import scfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  input  logic         byte_stall,
  input  byte_beat_t   byte_beat,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_beat_t result_beat,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  output int           fail_count,
  output int           outstanding
);

  logic [7:0]       start_mark;
  logic [7:0]       end_mark;
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_sum;
  logic [7:0]       hdr_dest;
  logic [7:0]       hdr_src;
  logic [7:0]       hdr_cmd;
  logic [7:0]       hdr_len;
  logic             start_ok;
  logic             sum_ok;
  result_beat_t     pending_results[$];

  initial fail_count = 0;

  task automatic clear_frame_state();
    frame_pos = '0;
    frame_sum = '0;
    hdr_dest  = '0;
    hdr_src   = '0;
    hdr_cmd   = '0;
    hdr_len   = '0;
    start_ok  = 1'b0;
    sum_ok    = 1'b0;
  endtask

  function automatic string beat_text(input result_beat_t r);
    return $sformatf("kind=%0d byte=%02h verdict=%0d dst=%02h src=%02h cmd=%02h len=%02h",
                     r.item_kind, r.payload_byte, r.verdict, r.dest_address,
                     r.source_address, r.command_code, r.payload_count);
  endfunction

  // advance the frame state by one byte and queue the result it causes
  task automatic predict_beat(input byte_beat_t bt);
    result_beat_t r;
    logic [7:0]   b;
    int           p;
    int           total;
    logic         in_payload;
    b          = bt.data_byte;
    p          = int'(frame_pos);
    in_payload = 1'b0;
    if (p < int'(HEADER_BYTES)) begin
      case (p)
        0: start_ok = (b == start_mark);
        1: hdr_dest = b;
        2: hdr_src  = b;
        3: hdr_cmd  = b;
        default: hdr_len = b;
      endcase
      frame_sum = frame_sum + b;
    end else if (p - int'(HEADER_BYTES) < int'(hdr_len)) begin
      frame_sum  = frame_sum + b;
      in_payload = 1'b1;
    end else if (p - int'(HEADER_BYTES) == int'(hdr_len)) begin
      sum_ok = (b == frame_sum);
    end
    r                = '0;
    r.dest_address   = hdr_dest;
    r.source_address = hdr_src;
    r.command_code   = hdr_cmd;
    r.payload_count  = hdr_len;
    if (bt.end_of_package) begin
      total       = p + 1;
      r.item_kind = KIND_VERDICT;
      if (total < int'(FRAME_OVERHEAD))                         r.verdict = VERDICT_TOO_SHORT;
      else if (!start_ok || b != end_mark)                      r.verdict = VERDICT_BAD_MARKER;
      else if (total != int'(hdr_len) + int'(FRAME_OVERHEAD))   r.verdict = VERDICT_LEN_ERR;
      else if (!sum_ok)                                         r.verdict = VERDICT_CHECKSUM;
      else if (int'(hdr_len) >= int'(MAX_PAYLOAD))              r.verdict = VERDICT_TOO_LONG;
      else                                                      r.verdict = VERDICT_OK;
      pending_results.push_back(r);
      clear_frame_state();
    end else begin
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
      if (in_payload) begin
        r.item_kind    = KIND_PAYLOAD;
        r.payload_byte = b;
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("%0t: result beat with none expected: %s", $time, beat_text(got));
    end else begin
      want = pending_results.pop_front();
      if (got.item_kind !== want.item_kind || got.payload_byte !== want.payload_byte ||
          got.verdict !== want.verdict || got.dest_address !== want.dest_address ||
          got.source_address !== want.source_address ||
          got.command_code !== want.command_code ||
          got.payload_count !== want.payload_count) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", beat_text(want));
          $display("  actual   %s", beat_text(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_mark = '0;
      end_mark   = '0;
      clear_frame_state();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && !result_stall) check_result(result_beat);
      if (byte_valid && !byte_stall) predict_beat(byte_beat);
      if (cfg_we) begin
        if (cfg_index == CFG_START_MARKER) start_mark = cfg_data;
        else end_mark = cfg_data;
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives framed byte packages into the parser: a few directed frames, then
// mostly well-formed frames with random content mixed with corrupted frames,
// short packages and noise, across several marker settings, with random
// idling on both sides, a long result hold-off and one oversized package.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scfp_pkg::*;

  localparam int ITEM_TARGET = 1500;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         byte_valid   = 1'b0;
  logic         byte_stall;
  byte_beat_t   byte_beat    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_beat;
  logic         cfg_we       = 1'b0;
  logic [0:0]   cfg_index    = CFG_START_MARKER;
  logic [7:0]   cfg_data     = '0;

  int         fail_count;
  int         outstanding;
  int         cycle_count  = 0;
  int         bytes_sent   = 0;
  int         holds_asked  = 0;
  int         holds_served = 0;
  int         hold_left    = 0;
  logic       calm         = 1'b0;
  logic [7:0] cur_start    = '0;
  logic [7:0] cur_end      = '0;
  logic [7:0] frame_q[$];

  sum_checksum_frame_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  scfp_frame_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= 300;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // called at a rising edge; returns at the edge the beat is accepted
  task automatic send_byte(input logic [7:0] b, input logic eop);
    if (!calm && $urandom_range(0, 99) < 22) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= {b, eop};
    do @(posedge clk); while (!(byte_valid && !byte_stall));
    bytes_sent++;
  endtask

  task automatic send_frame_q();
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
  endtask

  // pause intake until every expected result is out, plus pipeline slack
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_END_MARKER;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = s;
    cur_end   = e;
  endtask

  // rewrite the checksum byte from the header and payload bytes
  task automatic seal_frame();
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < frame_q.size() - 2; i++) s = s + frame_q[i];
    frame_q[frame_q.size() - 2] = s;
  endtask

  task automatic build_frame(input logic [7:0] dst, input logic [7:0] src,
                             input logic [7:0] cmd, input int plen);
    frame_q.delete();
    frame_q.push_back(cur_start);
    frame_q.push_back(dst);
    frame_q.push_back(src);
    frame_q.push_back(cmd);
    frame_q.push_back(8'(plen));
    for (int i = 0; i < plen; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(8'h00);
    frame_q.push_back(cur_end);
    seal_frame();
  endtask

  task automatic random_frame(input int plen);
    build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), plen);
  endtask

  task automatic random_bytes(input int n);
    frame_q.delete();
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic make_random_package();
    int r;
    int plen;
    int k;
    r    = $urandom_range(0, 99);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 127) : $urandom_range(0, 24);
    if ($urandom_range(0, 99) < 4) plen = $urandom_range(128, 255);
    random_frame(plen);
    if (r < 60) begin
      // well formed
    end else if (r < 68) begin
      frame_q[frame_q.size() - 2] ^= 8'($urandom_range(1, 255));
    end else if (r < 74) begin
      frame_q[0] ^= 8'($urandom_range(1, 255));
    end else if (r < 80) begin
      frame_q[frame_q.size() - 1] ^= 8'($urandom_range(1, 255));
    end else if (r < 86) begin
      if ($urandom_range(0, 1) == 0) begin
        frame_q.delete($urandom_range(1, frame_q.size() - 2));
      end else begin
        // trailing bytes between checksum and end marker
        k = $urandom_range(1, 5);
        repeat (k) frame_q.insert(frame_q.size() - 1, 8'($urandom_range(0, 255)));
      end
    end else if (r < 92) begin
      random_bytes($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 0) frame_q[0] = cur_start;
    end else begin
      random_bytes($urandom_range(1, 40));
    end
  endtask

  initial begin
    int pkg_count;
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, markers at reset value
    build_frame(8'hFF, 8'h00, 8'hAA, 0);
    send_frame_q();
    frame_q.delete();
    frame_q.push_back(8'h5C);
    send_frame_q();
    build_frame(8'h00, 8'hFF, 8'h55, 1);
    frame_q[5] = 8'hFF;
    seal_frame();
    send_frame_q();
    // last byte lands inside the payload
    build_frame(8'h12, 8'h34, 8'h56, 3);
    while (frame_q.size() > 7) void'(frame_q.pop_back());
    send_frame_q();

    wait_drained();
    set_markers(8'h7E, 8'h7F);

    pkg_count = 0;
    phase     = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (pkg_count % 30 == 29) begin
        wait_drained();
        case (phase % 5)
          0: set_markers(8'hFF, 8'hFF);
          1: set_markers(8'h00, 8'hFF);
          2: set_markers(8'hFF, 8'h00);
          3: set_markers(8'hA5, 8'h5A);
          default: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
        phase++;
      end
      if (pkg_count == 12) begin
        holds_asked <= holds_asked + 1;
        random_frame(60);
      end else if (pkg_count == 25) begin
        // oversized package: position counter saturates
        random_bytes(520);
        frame_q[0]   = cur_start;
        frame_q[519] = cur_end;
      end else begin
        make_random_package();
      end
      if (pkg_count == 35) calm <= 1'b1;
      if (pkg_count == 65) calm <= 1'b0;
      send_frame_q();
      pkg_count++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("failures: %0d, results still expected: %0d", fail_count, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/scfp_pkg.sv
sv/scfp_frame.sv
sv/scfp_out_buf.sv
sv/sum_checksum_frame_parser_core.sv
sv/scfp_checker.sv
verif/scfp_frame_checker.sv
verif/tb.sv
